// ===== sv/pida_pkg.sv =====
// shared types and codes for the positional insert/delete array
package pida_pkg;

  // operation kinds carried on tuser
  typedef enum logic [2:0] {
    K_BEGIN  = 3'd0,
    K_FILL   = 3'd1,
    K_GET    = 3'd2,
    K_SET    = 3'd3,
    K_INSERT = 3'd4,
    K_REMOVE = 3'd5
  } kind_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } stat_e;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_GET,
    S_UP,
    S_PUT,
    S_DN
  } state_e;

  // memory write source
  typedef enum logic [1:0] {
    W_VAL_POS,
    W_VAL_ADDR,
    W_RD_UP,
    W_RD_DN
  } wsrc_e;

  // memory read / pointer source
  typedef enum logic [2:0] {
    R_ZERO,
    R_POS,
    R_LAST,
    R_POS_NEXT,
    R_ADDR_DEC,
    R_ADDR_INC
  } rsrc_e;

  // length update
  typedef enum logic [1:0] {
    L_HOLD,
    L_START,
    L_INC,
    L_DEC
  } lop_e;

  // field widths
  localparam int unsigned KindW  = 3;
  localparam int unsigned PosW   = 7;
  localparam int unsigned WordW  = 32;
  localparam int unsigned StatW  = 2;
  localparam int unsigned LenW   = 7;
  localparam int unsigned StartW = 7;

  // commands from controller to datapath
  typedef struct packed {
    logic  take;
    logic  ptr_ld;
    rsrc_e rsrc;
    logic  we;
    wsrc_e wsrc;
    lop_e  lop;
    logic  res_ld;
    stat_e res_st;
    logic  res_rd;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    kind_e kind;
    logic  known_kind;
    logic  in_range;
    logic  ins_over;
    logic  full;
    logic  pos_at_end;
    logic  pos_last;
    logic  empty;
    logic  ptr_at_pos;
    logic  ptr_at_last;
    logic  out_free;
  } dp_sts_t;

endpackage

// ===== sv/pida_dp.sv =====
// datapath: entry memory, sweep pointer, length, config and result register
module pida_dp
  import pida_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [StartW-1:0]       cfg_wdata_i,
  input  logic [KindW-1:0]        in_kind_i,
  input  logic [PosW-1:0]         in_pos_i,
  input  logic signed [WordW-1:0] in_value_i,
  input  logic                    out_ready_i,
  input  dp_cmd_t                 cmd_i,
  output dp_sts_t                 sts_o,
  output logic                    out_valid_o,
  output logic signed [WordW-1:0] out_rd_o,
  output logic [StatW-1:0]        out_st_o,
  output logic [LenW-1:0]         out_len_o
);

  localparam int unsigned AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned LW  = $clog2(CAPACITY + 1);
  localparam int unsigned CW  = (LW > PosW) ? LW : PosW;
  localparam int unsigned CWL = (CW > LenW) ? CW : LenW;

  logic [StartW-1:0]       start_q;
  logic [LW-1:0]           live_q, live_d;
  logic [AW-1:0]           ptr_q;
  logic [PosW-1:0]         pos_q;
  logic signed [WordW-1:0] val_q;
  logic signed [WordW-1:0] rdata_q;
  logic signed [WordW-1:0] mem_q [CAPACITY];

  logic                    out_valid_q;
  logic signed [WordW-1:0] rd_q;
  logic [StatW-1:0]        st_q;
  logic [LenW-1:0]         len_q;

  logic [CW-1:0]           pos_w, cur_pos, live_w, ptr_w, start_w;
  logic [CWL-1:0]          live_dw;
  logic signed [WordW-1:0] cur_val;
  logic [AW-1:0]           raddr, waddr;
  logic signed [WordW-1:0] wdata;

  // operand selection: input fields on the accepting cycle, latched ones later
  assign pos_w   = CW'(in_pos_i);
  assign cur_pos = cmd_i.take ? pos_w : CW'(pos_q);
  assign cur_val = cmd_i.take ? in_value_i : val_q;
  assign live_w  = CW'(live_q);
  assign ptr_w   = CW'(ptr_q);
  assign start_w = CW'(start_q);

  // range checks and sweep end detection
  always_comb begin
    sts_o.kind        = kind_e'(in_kind_i);
    sts_o.known_kind  = (in_kind_i <= KindW'(K_REMOVE));
    sts_o.in_range    = (pos_w < live_w);
    sts_o.ins_over    = (pos_w > live_w);
    sts_o.full        = (live_w == CW'(CAPACITY));
    sts_o.pos_at_end  = (pos_w == live_w);
    sts_o.pos_last    = ((pos_w + CW'(1)) == live_w);
    sts_o.empty       = (live_q == '0);
    sts_o.ptr_at_pos  = (ptr_w == CW'(pos_q));
    sts_o.ptr_at_last = ((ptr_w + CW'(1)) == live_w);
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

  // read address select
  always_comb begin
    case (cmd_i.rsrc)
      R_ZERO:     raddr = '0;
      R_POS:      raddr = AW'(cur_pos);
      R_LAST:     raddr = AW'(live_w - CW'(1));
      R_POS_NEXT: raddr = AW'(pos_w + CW'(1));
      R_ADDR_DEC: raddr = ptr_q - AW'(1);
      R_ADDR_INC: raddr = ptr_q + AW'(1);
      default:    raddr = '0;
    endcase
  end

  // write address and data select
  always_comb begin
    case (cmd_i.wsrc)
      W_VAL_POS: begin
        waddr = AW'(cur_pos);
        wdata = cur_val;
      end
      W_VAL_ADDR: begin
        waddr = ptr_q;
        wdata = val_q;
      end
      W_RD_UP: begin
        waddr = ptr_q + AW'(1);
        wdata = rdata_q;
      end
      W_RD_DN: begin
        waddr = ptr_q - AW'(1);
        wdata = rdata_q;
      end
      default: begin
        waddr = ptr_q;
        wdata = val_q;
      end
    endcase
  end

  // next length, begin saturates at capacity
  always_comb begin
    case (cmd_i.lop)
      L_START: live_d = (start_w > CW'(CAPACITY)) ? LW'(CAPACITY) : LW'(start_w);
      L_INC:   live_d = live_q + LW'(1);
      L_DEC:   live_d = live_q - LW'(1);
      default: live_d = live_q;
    endcase
  end

  assign live_dw = CWL'(live_d);

  // entry memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.ptr_ld) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // operand latches and sweep pointer
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      pos_q <= in_pos_i;
      val_q <= in_value_i;
    end
    if (cmd_i.ptr_ld) begin
      ptr_q <= raddr;
    end
  end

  // config register and live length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= StartW'(5);
      live_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        start_q <= cfg_wdata_i;
      end
      live_q <= live_d;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_ld) begin
      rd_q  <= cmd_i.res_rd ? rdata_q : '0;
      st_q  <= cmd_i.res_st;
      len_q <= live_dw[LenW-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rd_o    = rd_q;
  assign out_st_o    = st_q;
  assign out_len_o   = len_q;

endmodule

// ===== sv/pida_ctrl.sv =====
// controller: sequences each operation over the datapath
module pida_ctrl
  import pida_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o,
  output state_e  state_o
);

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE) && sts_i.out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign state_o    = state_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && sts_i.known_kind) begin
          case (sts_i.kind)
            K_FILL:   if (!sts_i.empty) state_d = S_FILL;
            K_GET:    if (sts_i.in_range) state_d = S_GET;
            K_INSERT: begin
              if (!sts_i.ins_over && !sts_i.full && !sts_i.pos_at_end) begin
                state_d = S_UP;
              end
            end
            K_REMOVE: if (sts_i.in_range && !sts_i.pos_last) state_d = S_DN;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_FILL:  if (sts_i.ptr_at_last) state_d = S_IDLE;
      S_GET:   state_d = S_IDLE;
      S_UP:    if (sts_i.ptr_at_pos) state_d = S_PUT;
      S_PUT:   state_d = S_IDLE;
      S_DN:    if (sts_i.ptr_at_last) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o        = '0;
    cmd_o.rsrc   = R_ZERO;
    cmd_o.wsrc   = W_VAL_POS;
    cmd_o.lop    = L_HOLD;
    cmd_o.res_st = ST_OK;
    cmd_o.take   = accept;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (!sts_i.known_kind) begin
            cmd_o.res_ld = 1'b1;
          end else begin
            case (sts_i.kind)
              K_BEGIN: begin
                cmd_o.lop    = L_START;
                cmd_o.res_ld = 1'b1;
              end
              K_FILL: begin
                if (sts_i.empty) begin
                  cmd_o.res_ld = 1'b1;
                end else begin
                  cmd_o.ptr_ld = 1'b1;
                  cmd_o.rsrc   = R_ZERO;
                end
              end
              K_GET: begin
                if (sts_i.in_range) begin
                  cmd_o.ptr_ld = 1'b1;
                  cmd_o.rsrc   = R_POS;
                end else begin
                  cmd_o.res_ld = 1'b1;
                  cmd_o.res_st = ST_RANGE;
                end
              end
              K_SET: begin
                cmd_o.res_ld = 1'b1;
                if (sts_i.in_range) begin
                  cmd_o.we   = 1'b1;
                  cmd_o.wsrc = W_VAL_POS;
                end else begin
                  cmd_o.res_st = ST_RANGE;
                end
              end
              K_INSERT: begin
                if (sts_i.ins_over) begin
                  cmd_o.res_ld = 1'b1;
                  cmd_o.res_st = ST_RANGE;
                end else if (sts_i.full) begin
                  cmd_o.res_ld = 1'b1;
                  cmd_o.res_st = ST_FULL;
                end else if (sts_i.pos_at_end) begin
                  cmd_o.we     = 1'b1;
                  cmd_o.wsrc   = W_VAL_POS;
                  cmd_o.lop    = L_INC;
                  cmd_o.res_ld = 1'b1;
                end else begin
                  cmd_o.ptr_ld = 1'b1;
                  cmd_o.rsrc   = R_LAST;
                end
              end
              K_REMOVE: begin
                if (!sts_i.in_range) begin
                  cmd_o.res_ld = 1'b1;
                  cmd_o.res_st = ST_RANGE;
                end else if (sts_i.pos_last) begin
                  cmd_o.lop    = L_DEC;
                  cmd_o.res_ld = 1'b1;
                end else begin
                  cmd_o.ptr_ld = 1'b1;
                  cmd_o.rsrc   = R_POS_NEXT;
                end
              end
              default: cmd_o.res_ld = 1'b1;
            endcase
          end
        end
      end
      // write the value over each live entry
      S_FILL: begin
        cmd_o.we   = 1'b1;
        cmd_o.wsrc = W_VAL_ADDR;
        if (sts_i.ptr_at_last) begin
          cmd_o.res_ld = 1'b1;
        end else begin
          cmd_o.ptr_ld = 1'b1;
          cmd_o.rsrc   = R_ADDR_INC;
        end
      end
      S_GET: begin
        cmd_o.res_ld = 1'b1;
        cmd_o.res_rd = 1'b1;
      end
      // move entries up one place, top down
      S_UP: begin
        cmd_o.we   = 1'b1;
        cmd_o.wsrc = W_RD_UP;
        if (!sts_i.ptr_at_pos) begin
          cmd_o.ptr_ld = 1'b1;
          cmd_o.rsrc   = R_ADDR_DEC;
        end
      end
      S_PUT: begin
        cmd_o.we     = 1'b1;
        cmd_o.wsrc   = W_VAL_POS;
        cmd_o.lop    = L_INC;
        cmd_o.res_ld = 1'b1;
      end
      // move entries down one place, bottom up
      S_DN: begin
        cmd_o.we   = 1'b1;
        cmd_o.wsrc = W_RD_DN;
        if (sts_i.ptr_at_last) begin
          cmd_o.lop    = L_DEC;
          cmd_o.res_ld = 1'b1;
        end else begin
          cmd_o.ptr_ld = 1'b1;
          cmd_o.rsrc   = R_ADDR_INC;
        end
      end
      default: cmd_o.res_ld = 1'b0;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/positional_insert_delete_array.sv =====
// Begin, set, errors, unused kinds, insert at pos==length and remove of the last entry
// load their result on the accepting cycle; get reads the entry first. Shifts and fill
// move one entry per cycle through the single-write, registered-read entry memory; one
// item is in work at a time, the next taken once its result is loaded and the output
// register is free or draining. Reset clears the length to zero, start_length to 5 and
// the result valid; entry contents are not cleared and read as undefined until written.
module positional_insert_delete_array
  import pida_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // position[6:0], value[38:7], zero pad[39]
  input  logic [2:0]  s_axis_tuser,  // kind[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // read_value[31:0], status[33:32], length_now[40:34], pad
);

  dp_cmd_t                 cmd;
  dp_sts_t                 sts;
  state_e                  state;
  logic signed [WordW-1:0] out_rd;
  logic [StatW-1:0]        out_st;
  logic [LenW-1:0]         out_len;

  pida_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .state_o    (state)
  );

  pida_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_kind_i   (s_axis_tuser),
    .in_pos_i    (s_axis_tdata[6:0]),
    .in_value_i  (s_axis_tdata[38:7]),
    .out_ready_i (m_axis_tready),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_rd_o    (out_rd),
    .out_st_o    (out_st),
    .out_len_o   (out_len)
  );

  assign m_axis_tdata = {7'd0, out_len, out_st, out_rd};

  localparam logic [LenW-1:0] CapLen = LenW'(CAPACITY);

  // a result only loads into a free or draining output register
  a_res_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.res_ld |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result loaded over an untaken result");

  // every accepted item leaves either a result or work in progress
  a_accept_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (m_axis_tvalid || state != S_IDLE))
    else $error("accepted item vanished");

  // a full status only reports a length at capacity
  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_st == ST_FULL) |-> (out_len == CapLen))
    else $error("full status with length below capacity");

  // only a get returns a nonzero word, and never with an error status
  a_rd_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_st != ST_OK) |-> (out_rd == '0))
    else $error("read data on an error result");

endmodule
